>>> rtl/heq_pkg.sv
package heq_pkg;

  localparam int MAP_DEPTH = 256;
  localparam int MAP_AW    = 8;
  localparam int PIX_W     = 8;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_CNT_WR,
    ST_MAP_OUT,
    ST_B1_RD,
    ST_B1_ACC,
    ST_B2_RD,
    ST_B2_ACC,
    ST_B2_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_B2_WR
  } heq_state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_CNT_WR,
    DP_OUT_LOAD,
    DP_CLR,
    DP_B1_RD,
    DP_B1_ACC,
    DP_B2_RD,
    DP_B2_ACC,
    DP_B2_MUL,
    DP_DIV_INIT,
    DP_DIV,
    DP_B2_WR
  } heq_op_t;

  typedef struct packed {
    heq_op_t op;
  } heq_cmd_t;

  typedef struct packed {
    logic bins_end;
    logic all_end;
    logic div_done;
    logic out_free;
    logic last;
  } heq_status_t;

endpackage

>>> rtl/heq_if.sv
interface heq_in_if;
  import heq_pkg::*;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [PIX_W-1:0] pixel;
  logic             last_pixel;
  modport source (output valid, req_type, pixel, last_pixel, input ready);
  modport sink   (input valid, req_type, pixel, last_pixel, output ready);
endinterface

interface heq_out_if;
  import heq_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_pixel;
  logic             last_out;
  modport source (output valid, out_pixel, last_out, input ready);
  modport sink   (input valid, out_pixel, last_out, output ready);
endinterface

>>> rtl/heq_ram.sv
module heq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/heq_ctrl.sv
module heq_ctrl import heq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_req_type,
  output logic        in_ready,
  input  heq_status_t status,
  output heq_cmd_t    cmd
);

  heq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_NOP;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLR: begin
        cmd.op = DP_CLR;
        if (status.all_end) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = DP_LATCH;
          state_nxt = in_req_type ? ST_MAP_OUT : ST_CNT_WR;
        end
      end
      ST_CNT_WR: begin
        cmd.op    = DP_CNT_WR;
        state_nxt = status.last ? ST_B1_RD : ST_IDLE;
      end
      ST_MAP_OUT: begin
        if (status.out_free) begin
          cmd.op    = DP_OUT_LOAD;
          state_nxt = status.last ? ST_CLR : ST_IDLE;
        end
      end
      ST_B1_RD: begin
        cmd.op    = DP_B1_RD;
        state_nxt = ST_B1_ACC;
      end
      ST_B1_ACC: begin
        cmd.op    = DP_B1_ACC;
        state_nxt = status.bins_end ? ST_B2_RD : ST_B1_RD;
      end
      ST_B2_RD: begin
        cmd.op    = DP_B2_RD;
        state_nxt = ST_B2_ACC;
      end
      ST_B2_ACC: begin
        cmd.op    = DP_B2_ACC;
        state_nxt = ST_B2_MUL;
      end
      ST_B2_MUL: begin
        cmd.op    = DP_B2_MUL;
        state_nxt = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.op    = DP_DIV_INIT;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = DP_DIV;
        if (status.div_done) state_nxt = ST_B2_WR;
      end
      ST_B2_WR: begin
        cmd.op    = DP_B2_WR;
        state_nxt = status.all_end ? ST_IDLE : ST_B2_RD;
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

endmodule

>>> rtl/heq_dp.sv
module heq_dp import heq_pkg::*; #(
  parameter int GRAY_LEVELS = 256,
  parameter int COUNT_BITS  = 25
) (
  input  logic             clk,
  input  logic             rst_n,
  input  heq_cmd_t         cmd,
  output heq_status_t      status,
  input  logic [PIX_W-1:0] in_pixel,
  input  logic             in_last,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [PIX_W-1:0] out_pixel,
  output logic             out_last
);

  localparam int BW = $clog2(GRAY_LEVELS);
  localparam int NI = (GRAY_LEVELS > MAP_DEPTH) ? GRAY_LEVELS : MAP_DEPTH;
  localparam int IW = $clog2(NI);
  localparam int QB = BW;
  localparam int KW = $clog2(QB);
  localparam int NW = COUNT_BITS + QB;
  localparam int W  = NW + 2;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  logic [IW-1:0]         idx_r, pix_idx_r;
  logic                  last_r, clr_map_r;
  logic [COUNT_BITS-1:0] total_r, running_r, cdfmin_r, den_r;
  logic                  found_r, en_r;
  logic [NW-1:0]         num_r;
  logic [W-1:0]          rem_r;
  logic [QB-1:0]         q_r;
  logic [KW-1:0]         k_r;
  logic                  out_valid_r, out_last_r;
  logic [PIX_W-1:0]      out_pixel_r;

  logic [IW-1:0]         in_ext, in_idx;
  logic                  in_bins, in_map;
  logic [COUNT_BITS:0]   run_sum, cnt_sum, tot_sum;
  logic [COUNT_BITS-1:0] run_sat, cnt_sat, tot_sat;
  logic [W-1:0]          trial;
  logic [QB+7:0]         q_ext;
  logic [PIX_W-1:0]      map_val;

  logic                  bin_we, map_we;
  logic [BW-1:0]         bin_waddr, bin_raddr;
  logic [COUNT_BITS-1:0] bin_wdata, bin_rdata;
  logic [MAP_AW-1:0]     map_waddr, map_raddr;
  logic [PIX_W-1:0]      map_wdata, map_rdata;

  assign in_ext  = IW'(in_pixel);
  assign in_idx  = (in_ext > IW'(GRAY_LEVELS - 1)) ? IW'(GRAY_LEVELS - 1) : in_ext;
  assign in_bins = {1'b0, idx_r} < (IW + 1)'(GRAY_LEVELS);
  assign in_map  = {1'b0, idx_r} < (IW + 1)'(MAP_DEPTH);

  assign run_sum = {1'b0, running_r} + {1'b0, bin_rdata};
  assign run_sat = run_sum[COUNT_BITS] ? CMAX : run_sum[COUNT_BITS-1:0];
  assign cnt_sum = {1'b0, bin_rdata} + (COUNT_BITS + 1)'(1);
  assign cnt_sat = cnt_sum[COUNT_BITS] ? CMAX : cnt_sum[COUNT_BITS-1:0];
  assign tot_sum = {1'b0, total_r} + (COUNT_BITS + 1)'(1);
  assign tot_sat = tot_sum[COUNT_BITS] ? CMAX : tot_sum[COUNT_BITS-1:0];

  assign trial   = W'({den_r, 1'b0}) << k_r;
  assign q_ext   = (QB + 8)'(q_r);
  assign map_val = !en_r ? '0 : (q_ext > (QB + 8)'(255)) ? 8'hFF : q_ext[PIX_W-1:0];

  always_comb begin
    bin_we    = 1'b0;
    bin_waddr = idx_r[BW-1:0];
    bin_wdata = '0;
    map_we    = 1'b0;
    map_waddr = idx_r[MAP_AW-1:0];
    map_wdata = '0;
    bin_raddr = (cmd.op == DP_LATCH) ? in_idx[BW-1:0] : idx_r[BW-1:0];
    map_raddr = (cmd.op == DP_LATCH) ? in_idx[MAP_AW-1:0] : pix_idx_r[MAP_AW-1:0];
    case (cmd.op)
      DP_CNT_WR: begin
        bin_we    = 1'b1;
        bin_waddr = pix_idx_r[BW-1:0];
        bin_wdata = cnt_sat;
      end
      DP_CLR: begin
        bin_we = in_bins;
        map_we = clr_map_r && in_map;
      end
      DP_B2_WR: begin
        map_we    = in_map;
        map_wdata = map_val;
      end
      default: begin
      end
    endcase
  end

  heq_ram #(.WIDTH(COUNT_BITS), .DEPTH(GRAY_LEVELS)) u_bins (
    .clk, .we(bin_we), .waddr(bin_waddr), .wdata(bin_wdata),
    .raddr(bin_raddr), .rdata(bin_rdata)
  );

  heq_ram #(.WIDTH(PIX_W), .DEPTH(MAP_DEPTH)) u_map (
    .clk, .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      clr_map_r   <= 1'b1;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (cmd.op)
        DP_LATCH: begin
          pix_idx_r <= in_idx;
          last_r    <= in_last;
        end
        DP_CNT_WR: begin
          total_r <= tot_sat;
          if (last_r) begin
            idx_r     <= '0;
            running_r <= '0;
            cdfmin_r  <= '0;
            found_r   <= 1'b0;
          end
        end
        DP_OUT_LOAD: begin
          out_valid_r <= 1'b1;
          out_pixel_r <= map_rdata;
          out_last_r  <= last_r;
          if (last_r) begin
            idx_r     <= '0;
            clr_map_r <= 1'b0;
          end
        end
        DP_CLR: begin
          total_r <= '0;
          idx_r   <= idx_r + IW'(1);
        end
        DP_B1_ACC: begin
          running_r <= run_sat;
          if (!found_r && run_sat != '0) begin
            cdfmin_r <= run_sat;
            found_r  <= 1'b1;
          end
          if (status.bins_end) begin
            idx_r     <= '0;
            running_r <= '0;
          end else begin
            idx_r <= idx_r + IW'(1);
          end
        end
        DP_B2_ACC: begin
          if (in_bins) running_r <= run_sat;
        end
        DP_B2_MUL: begin
          en_r  <= in_bins && (total_r > cdfmin_r) && (running_r >= cdfmin_r);
          den_r <= total_r - cdfmin_r;
          num_r <= NW'(running_r - cdfmin_r) * NW'(GRAY_LEVELS - 1);
        end
        DP_DIV_INIT: begin
          rem_r <= {1'b0, num_r, 1'b0} + W'(den_r);
          q_r   <= '0;
          k_r   <= KW'(QB - 1);
        end
        DP_DIV: begin
          if (rem_r >= trial) begin
            rem_r    <= rem_r - trial;
            q_r[k_r] <= 1'b1;
          end
          k_r <= k_r - KW'(1);
        end
        DP_B2_WR: begin
          idx_r <= idx_r + IW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  assign status.bins_end = idx_r == IW'(GRAY_LEVELS - 1);
  assign status.all_end  = idx_r == IW'(NI - 1);
  assign status.div_done = k_r == '0;
  assign status.out_free = !out_valid_r || out_ready;
  assign status.last     = last_r;

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_last  = out_last_r;

endmodule

>>> rtl/histogram_equalizer_top.sv
// Two-pass 8-bit histogram equalizer, one pixel word at a time. A count-pass word
// is a bin read, then a saturating write. A map-pass word is a map read, then an
// output register load, which waits while the output register is still held by
// the sink. The last count-pass word starts the map build: a CDF sweep over
// GRAY_LEVELS bins, then for each of max(GRAY_LEVELS,256) levels a division by
// the restoring divider, which produces one quotient bit per cycle. After reset
// and after the last map-pass word a clearing sweep over max(GRAY_LEVELS,256)
// entries runs with in_s.ready low.
module histogram_equalizer_top import heq_pkg::*; #(
  parameter int GRAY_LEVELS = 256,
  parameter int COUNT_BITS  = 25
) (
  input  logic      clk,
  input  logic      rst_n,
  heq_in_if.sink    in_s,
  heq_out_if.source out_m
);

  heq_cmd_t    cmd;
  heq_status_t status;

  heq_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_s.valid), .in_req_type(in_s.req_type), .in_ready(in_s.ready),
    .status, .cmd
  );

  heq_dp #(.GRAY_LEVELS(GRAY_LEVELS), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk, .rst_n, .cmd, .status,
    .in_pixel(in_s.pixel), .in_last(in_s.last_pixel),
    .out_ready(out_m.ready), .out_valid(out_m.valid),
    .out_pixel(out_m.out_pixel), .out_last(out_m.last_out)
  );

endmodule

>>> rtl/heq_checker.sv
module heq_checker import heq_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] out_pixel,
  input logic             last_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(last_out))
    else $error("output word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a word in flight");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && last_out |-> !in_ready)
    else $error("input open during clear sweep");

endmodule

bind histogram_equalizer_top heq_checker u_heq_checker (
  .clk, .rst_n,
  .in_valid(in_s.valid), .in_ready(in_s.ready),
  .out_valid(out_m.valid), .out_ready(out_m.ready),
  .out_pixel(out_m.out_pixel), .last_out(out_m.last_out)
);

>>> tb/testbench.sv
module testbench;
  import heq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVELS     = 256;
  localparam int CNT_W      = 25;
  localparam int N_ITEMS    = 1150;
  localparam int DRAIN_WAIT = 4500;
  localparam int STALL_MAX  = 20000;

  localparam bit REQ_COUNT = 1'b0;
  localparam bit REQ_MAP   = 1'b1;

  typedef struct {
    bit       req;
    bit [7:0] pix;
    bit       lst;
    bit       hold;
  } pix_word_t;

  typedef struct {
    bit [7:0] level;
    bit       lst;
  } eq_word_t;

  logic clk;
  logic rst_n;

  heq_in_if  in_bus();
  heq_out_if out_bus();

  histogram_equalizer_top u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_bus),
    .out_m (out_bus)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // predictor state
  bit [CNT_W-1:0] hist_bins [LEVELS];
  bit [CNT_W-1:0] hist_total;
  bit [7:0]       eq_lut    [256];

  pix_word_t pending [$];
  eq_word_t  eq_expected [$];

  int  n_mismatch, n_fail, n_words_in, n_words_out, n_builds, n_flat;
  int  in_gap, out_gap, stall_cnt;
  logic in_took;

  function automatic bit [CNT_W-1:0] sat_inc(bit [CNT_W-1:0] a, bit [CNT_W-1:0] b);
    longint unsigned s;
    s = longint'(a) + longint'(b);
    return (s > {CNT_W{1'b1}}) ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  function automatic void rebuild_lut();
    bit [CNT_W-1:0]  cdf, cdf_min;
    bit              seen;
    longint unsigned num, den, v;
    cdf = '0; cdf_min = '0; seen = 1'b0;
    for (int i = 0; i < LEVELS; i++) begin
      cdf = sat_inc(cdf, hist_bins[i]);
      if (!seen && cdf != 0) begin
        cdf_min = cdf;
        seen = 1'b1;
      end
    end
    if (hist_total == cdf_min) n_flat++;
    cdf = '0;
    for (int i = 0; i < LEVELS; i++) begin
      cdf = sat_inc(cdf, hist_bins[i]);
      v = 0;
      if (hist_total > cdf_min && cdf >= cdf_min) begin
        den = longint'(hist_total - cdf_min);
        num = longint'(cdf - cdf_min) * (LEVELS - 1);
        v = (2 * num + den) / (2 * den);
      end
      if (v > 255) v = 255;
      eq_lut[i] = v[7:0];
    end
    n_builds++;
  endfunction

  function automatic void predict_word(bit req, bit [7:0] pix, bit lst);
    eq_word_t e;
    if (req == REQ_COUNT) begin
      hist_bins[pix] = sat_inc(hist_bins[pix], CNT_W'(1));
      hist_total = sat_inc(hist_total, CNT_W'(1));
      if (lst) rebuild_lut();
    end else begin
      e.level = eq_lut[pix];
      e.lst = lst;
      eq_expected.push_back(e);
      if (lst) begin
        foreach (hist_bins[i]) hist_bins[i] = '0;
        hist_total = '0;
      end
    end
  endfunction

  // monitor
  always @(posedge clk) begin
    eq_word_t e;
    in_took = rst_n && in_bus.valid && in_bus.ready;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        n_words_out++;
        if (eq_expected.size() == 0) begin
          n_fail++;
          if (n_mismatch < 10)
            $display("unexpected word: level=%0d last=%0b", out_bus.out_pixel,
                     out_bus.last_out);
          n_mismatch++;
        end else begin
          e = eq_expected.pop_front();
          if (out_bus.out_pixel !== e.level || out_bus.last_out !== e.lst) begin
            n_fail++;
            if (n_mismatch < 10)
              $display("mismatch word %0d: exp level=%0d last=%0b, got level=%0d last=%0b",
                       n_words_out, e.level, e.lst, out_bus.out_pixel, out_bus.last_out);
            n_mismatch++;
          end
        end
      end
      if (in_took) begin
        n_words_in++;
        predict_word(in_bus.req_type, in_bus.pixel, in_bus.last_pixel);
      end
      if (in_took || (out_bus.valid && out_bus.ready)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_MAX) begin
        $display("watchdog: no progress for %0d cycles", STALL_MAX);
        $display("[histogram_equalizer_top] ERROR");
        $finish;
      end
    end
  end

  // driver
  always @(negedge clk) begin
    pix_word_t w;
    if (rst_n && (!in_bus.valid || in_took)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_bus.valid <= 1'b0;
      end else if (pending.size() > 0 && !(pending[0].hold && eq_expected.size() > 0)) begin
        w = pending.pop_front();
        in_bus.valid      <= 1'b1;
        in_bus.req_type   <= w.req;
        in_bus.pixel      <= w.pix;
        in_bus.last_pixel <= w.lst;
        if (pending.size() > 120 && (pending.size() % 300) < 180 &&
            $urandom_range(0, 7) == 0)
          in_gap = $urandom_range(1, 15);
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_gap > 0) begin
        out_gap--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        if (pending.size() > 120 && (pending.size() % 250) > 90 &&
            $urandom_range(0, 5) == 0)
          out_gap = $urandom_range(1, 15);
      end
    end
  end

  function automatic void push_word(bit req, bit [7:0] pix, bit lst, bit hold = 1'b0);
    pix_word_t w;
    w.req = req; w.pix = pix; w.lst = lst; w.hold = hold;
    pending.push_back(w);
  endfunction

  function automatic void push_image(int n_cnt, int n_map, int lo, int hi,
                                     bit cnt_last, bit map_last);
    for (int i = 0; i < n_cnt; i++)
      push_word(REQ_COUNT, 8'($urandom_range(lo, hi)), cnt_last && i == n_cnt - 1);
    for (int i = 0; i < n_map; i++)
      push_word(REQ_MAP,
                (i % 3 == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(lo, hi)),
                map_last && i == n_map - 1);
  endfunction

  initial begin
    int lo, hi, kind;
    bit held;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.req_type = REQ_COUNT;
    in_bus.pixel = '0;
    in_bus.last_pixel = 1'b0;
    out_bus.ready = 1'b0;
    in_took = 1'b0;
    in_gap = 0; out_gap = 0; stall_cnt = 0;
    n_mismatch = 0; n_fail = 0; n_words_in = 0; n_words_out = 0;
    n_builds = 0; n_flat = 0;
    hist_total = '0;
    foreach (hist_bins[i]) hist_bins[i] = '0;
    foreach (eq_lut[i]) eq_lut[i] = '0;

    // map pass before any histogram: all zero
    push_word(REQ_MAP, 8'd0, 1'b0);
    push_word(REQ_MAP, 8'd255, 1'b1);
    // flat image
    push_word(REQ_COUNT, 8'd128, 1'b0);
    push_word(REQ_COUNT, 8'd128, 1'b1);
    push_word(REQ_MAP, 8'd128, 1'b0);
    push_word(REQ_MAP, 8'd0, 1'b1);
    // extremes, levels below cdfmin
    push_word(REQ_COUNT, 8'd255, 1'b0);
    push_word(REQ_COUNT, 8'd0, 1'b0);
    push_word(REQ_COUNT, 8'd0, 1'b0);
    push_word(REQ_COUNT, 8'd170, 1'b1);
    push_word(REQ_MAP, 8'd0, 1'b0);
    push_word(REQ_MAP, 8'd85, 1'b0);
    push_word(REQ_MAP, 8'd170, 1'b0);
    push_word(REQ_MAP, 8'd255, 1'b0);
    // rebuild without clearing, then map
    push_word(REQ_COUNT, 8'd85, 1'b1);
    push_word(REQ_MAP, 8'd85, 1'b0);
    push_word(REQ_MAP, 8'd170, 1'b1);
    // single-pixel image
    push_word(REQ_COUNT, 8'd1, 1'b1);
    push_word(REQ_MAP, 8'd1, 1'b1);

    held = 1'b0;
    while (pending.size() < N_ITEMS) begin
      if (!held && pending.size() > N_ITEMS / 2) begin
        push_word(REQ_MAP, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
        held = 1'b1;
      end
      kind = $urandom_range(0, 9);
      if ($urandom_range(0, 1)) begin
        lo = 0; hi = 255;
      end else begin
        lo = $urandom_range(0, 250);
        hi = lo + $urandom_range(0, 255 - lo);
      end
      if (kind < 7)
        push_image($urandom_range(1, 40), $urandom_range(1, 30), lo, hi, 1'b1, 1'b1);
      else if (kind == 7)
        push_image($urandom_range(1, 5), $urandom_range(1, 6), lo, hi, 1'b1, 1'b0);
      else if (kind == 8)
        push_image($urandom_range(1, 10), $urandom_range(0, 5), lo, hi, 1'b0, 1'b1);
      else
        push_image($urandom_range(1, 3), 0, lo, lo, 1'b1, 1'b0);
    end
    push_image(8, 8, 0, 255, 1'b1, 1'b1);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending.size() > 0 || in_bus.valid) @(posedge clk);
    while (eq_expected.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (eq_expected.size() > 0) n_fail += eq_expected.size();

    $display("covered %0d input words, %0d equalized words, %0d map builds (%0d flat)",
             n_words_in, n_words_out, n_builds, n_flat);
    $display("mismatches: %0d", n_fail);
    if (n_fail == 0)
      $display("[histogram_equalizer_top] OK");
    else
      $display("[histogram_equalizer_top] ERROR");
    $finish;
  end

endmodule
